/* rtl/ipv4_prefix_filter_table_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the prefix filter table
// Concurrent checks clocked on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef IPV4_PREFIX_FILTER_TABLE_CORE_ASSERT_SVH
`define IPV4_PREFIX_FILTER_TABLE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PFT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prefix filter table check failed");
// next-cycle implication
`define PFT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prefix filter table check failed");
`else
`define PFT_ASSERT_IMP(lbl, ante, cons)
`define PFT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/pft_pkg.sv */
// ---------------------------------------------------------------------------
// Prefix filter table package
// Transaction types, codes and the prefix mask helper.
// ---------------------------------------------------------------------------
package pft_pkg;

  localparam logic       OP_INSERT = 1'b0;
  localparam logic       OP_LOOKUP = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [5:0]  ADDR_BITS  = 6'd32;
  localparam logic [5:0]  MIN_PREFIX = 6'd2;

  typedef struct packed {
    logic        op;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic        is_ipv4;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] status;
  } rsp_t;

  // token that walks down the cell row
  typedef struct packed {
    logic        valid;
    logic        lookup;  // IPv4 lookup, compare in each used cell
    logic        write;   // accepted insert, lands in the cell at the fill count
    logic [31:0] key;     // lookup key, or masked network for insert
    logic [5:0]  plen;
    logic        hit;
    logic [1:0]  status;
  } token_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [5:0] sh;
    sh = ADDR_BITS - len;
    return ALL_ONES << sh;
  endfunction

endpackage

/* rtl/pft_cell.sv */
// ---------------------------------------------------------------------------
// Prefix filter table cell
// Holds one prefix entry, checks the passing token, hands it on registered.
// ---------------------------------------------------------------------------
module pft_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  pft_pkg::token_t   tok_in,
  input  logic [CNT_W-1:0]  count_in,
  output pft_pkg::token_t   tok_out,
  output logic [CNT_W-1:0]  count_out
);

  logic [31:0] entry_network;
  logic [5:0]  entry_length;
  logic        used;
  logic        match;
  logic        here;

  assign here  = (count_in == CNT_W'(INDEX));
  assign used  = (CNT_W'(INDEX) < count_in);
  assign match = tok_in.lookup && used &&
                 ((tok_in.key & pft_pkg::prefix_mask(entry_length)) == entry_network);

  // entry store, undefined until written
  always_ff @(posedge clk) begin
    if (tok_in.valid && tok_in.write && here) begin
      entry_network <= tok_in.key;
      entry_length  <= tok_in.plen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.lookup <= tok_in.lookup;
    tok_out.write  <= tok_in.write;
    tok_out.key    <= tok_in.key;
    tok_out.plen   <= tok_in.plen;
    tok_out.hit    <= tok_in.hit | match;
    tok_out.status <= tok_in.status;
    count_out      <= count_in;
  end

endmodule

/* rtl/ipv4_prefix_filter_table_core.sv */
// ---------------------------------------------------------------------------
// IPv4 prefix filter table core
// Each accepted token walks the row of entry cells, one cell per cycle and
//   one register per cell; the done strobe is the last cell's register. One
//   transaction at a time: start is taken again in the cycle the result is
//   strobed. The receiver cannot stall; done is one cycle.
// Reset: clears the fill count, busy and the token valids; entries are not
//   cleared, only cells below the fill count are ever compared.
// ---------------------------------------------------------------------------
`include "ipv4_prefix_filter_table_core_assert.svh"

module ipv4_prefix_filter_table_core #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pft_pkg::req_t  req,
  output logic           done,
  output pft_pkg::rsp_t  rsp
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int LAST  = TABLE_ENTRIES - 1;
  localparam bit MULTI = (TABLE_ENTRIES > 1);

  // tok[i] feeds cell i; tok[TABLE_ENTRIES] is the registered result
  pft_pkg::token_t  tok   [0:TABLE_ENTRIES];
  logic [CNT_W-1:0] cnt   [0:TABLE_ENTRIES];

  logic [CNT_W-1:0] entry_count;
  logic             accept;
  logic             len_ok;
  logic             full;
  logic             is_insert;
  logic             ins_ok;

  assign accept    = start && !busy;
  assign is_insert = (req.op == pft_pkg::OP_INSERT);
  assign len_ok    = (req.prefix_len >= pft_pkg::MIN_PREFIX) &&
                     (req.prefix_len <= pft_pkg::ADDR_BITS);
  assign full      = (entry_count == CNT_W'(TABLE_ENTRIES));
  assign ins_ok    = accept && is_insert && len_ok && !full;

  // Build the token at acceptance. Status is settled here: a bad length
  // wins over a full table. Insert keys are pre-masked to the prefix.
  always_comb begin
    tok[0].valid  = accept;
    tok[0].lookup = (req.op == pft_pkg::OP_LOOKUP) && req.is_ipv4;
    tok[0].write  = is_insert && len_ok && !full;
    tok[0].key    = is_insert ? (req.address & pft_pkg::prefix_mask(req.prefix_len))
                              : req.address;
    tok[0].plen   = req.prefix_len;
    tok[0].hit    = 1'b0;
    priority if (!is_insert) begin
      tok[0].status = pft_pkg::STATUS_OK;
    end else if (!len_ok) begin
      tok[0].status = pft_pkg::STATUS_BAD_LEN;
    end else if (full) begin
      tok[0].status = pft_pkg::STATUS_FULL;
    end else begin
      tok[0].status = pft_pkg::STATUS_OK;
    end
  end

  // snapshot before the increment: write slot for inserts, used span for lookups
  assign cnt[0] = entry_count;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    pft_cell #(
      .INDEX (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .tok_in    (tok[g]),
      .count_in  (cnt[g]),
      .tok_out   (tok[g+1]),
      .count_out (cnt[g+1])
    );
  end

  // busy drops as the token enters the last cell, so start is taken
  // again in the cycle the result shows
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      entry_count <= '0;
    end else begin
      if (accept && MULTI) begin
        busy <= 1'b1;
      end else if (tok[LAST].valid) begin
        busy <= 1'b0;
      end
      if (ins_ok) begin
        entry_count <= entry_count + CNT_W'(1);
      end
    end
  end

  assign done       = tok[TABLE_ENTRIES].valid;
  assign rsp.hit    = tok[TABLE_ENTRIES].hit;
  assign rsp.status = tok[TABLE_ENTRIES].status;

  `PFT_ASSERT_IMP(a_done_not_busy, done, !busy)
  `PFT_ASSERT_NXT(a_accept_busy, accept && MULTI, busy)
  `PFT_ASSERT_NXT(a_count_step, ins_ok, entry_count == $past(entry_count) + CNT_W'(1))
  `PFT_ASSERT_IMP(a_count_bound, 1'b1, entry_count <= CNT_W'(TABLE_ENTRIES))
  `PFT_ASSERT_IMP(a_hit_ok, done && rsp.hit, rsp.status == pft_pkg::STATUS_OK)

endmodule

/* test/ipv4_prefix_filter_table_core_tb.sv */
// ---------------------------------------------------------------------------
// IPv4 prefix filter table core testbench
// Drives insert and lookup transactions through the start/busy handshake and
// checks every done strobe against a shadow copy of the prefix table or a typed-in answer.
// ---------------------------------------------------------------------------
module ipv4_prefix_filter_table_core_tb;

  localparam int TABLE_ENTRIES = 64;
  localparam int DIR_ROWS      = 24;
  localparam int RAND_PER_PASS = 650;
  // Slowest run: ~2000 transactions, each the full walk of the cell row plus
  // random sender idling. Taken well over four times.
  localparam int CYCLE_LIMIT   = 1_200_000;

  // One row of the directed table. Where known is set, the answer is typed
  // in; otherwise the shadow table supplies it.
  typedef struct packed {
    pft_pkg::req_t cmd;
    logic          known;
    pft_pkg::rsp_t want;
  } vec_t;

  typedef struct {
    pft_pkg::req_t cmd;
    pft_pkg::rsp_t want;
  } pending_t;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  pft_pkg::req_t  req;
  logic           done;
  pft_pkg::rsp_t  rsp;

  // Shadow copy of the prefix table
  logic [31:0] shadow_net [TABLE_ENTRIES];
  logic [5:0]  shadow_len [TABLE_ENTRIES];
  int          shadow_fill;

  pending_t predicted_answers[$];
  int       mismatches;
  int       cycles;
  vec_t     dir_tab [DIR_ROWS];

  ipv4_prefix_filter_table_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Network mask for a prefix length of 2..32.
  function automatic logic [31:0] net_mask(input logic [5:0] plen);
    return ~(32'hFFFF_FFFF >> plen);
  endfunction

  // Answer of the table to one accepted transaction; inserts update the shadow.
  function automatic pft_pkg::rsp_t table_answer(input pft_pkg::req_t c);
    pft_pkg::rsp_t r;
    r = '0;
    r.status = pft_pkg::STATUS_OK;
    if (c.op == pft_pkg::OP_INSERT) begin
      if (c.prefix_len < pft_pkg::MIN_PREFIX || c.prefix_len > pft_pkg::ADDR_BITS) begin
        r.status = pft_pkg::STATUS_BAD_LEN;  // bad length wins over a full table
      end else if (shadow_fill >= TABLE_ENTRIES) begin
        r.status = pft_pkg::STATUS_FULL;
      end else begin
        shadow_net[shadow_fill] = c.address & net_mask(c.prefix_len);
        shadow_len[shadow_fill] = c.prefix_len;
        shadow_fill++;
      end
    end else if (c.is_ipv4) begin
      for (int i = 0; i < shadow_fill; i++) begin
        if ((c.address & net_mask(shadow_len[i])) == shadow_net[i]) r.hit = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic vec_t row(input logic op, input logic [31:0] addr,
                               input logic [5:0] plen, input logic v4,
                               input logic known, input logic hit,
                               input logic [1:0] status);
    vec_t v;
    v.cmd.op         = op;
    v.cmd.address    = addr;
    v.cmd.prefix_len = plen;
    v.cmd.is_ipv4    = v4;
    v.known          = known;
    v.want.hit       = hit;
    v.want.status    = status;
    return v;
  endfunction

  // Random transaction. Mostly lookups, many of them aimed inside or just
  // outside a stored prefix so that hits are common; inserts fill the table
  // early on and then keep probing the full-table path.
  function automatic pft_pkg::req_t make_txn();
    pft_pkg::req_t c;
    int            pick;
    int            idx;
    logic [31:0]   m;
    c.address    = $urandom;
    c.prefix_len = 6'($urandom);
    c.is_ipv4    = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      c.op = pft_pkg::OP_INSERT;
      pick = $urandom_range(0, 99);
      if (pick < 70)      c.prefix_len = 6'($urandom_range(8, 32));
      else if (pick < 85) c.prefix_len = 6'($urandom_range(2, 7));
      else if (pick < 92) c.prefix_len = 6'($urandom_range(0, 1));
      else                c.prefix_len = 6'($urandom_range(33, 63));
    end else begin
      c.op      = pft_pkg::OP_LOOKUP;
      c.is_ipv4 = ($urandom_range(0, 9) != 0);
      if (shadow_fill > 0 && $urandom_range(0, 99) < 60) begin
        idx = $urandom_range(0, shadow_fill - 1);
        m   = net_mask(shadow_len[idx]);
        c.address = shadow_net[idx] | ($urandom & ~m);
        // near miss: flip one bit inside the prefix
        if ($urandom_range(0, 4) == 0)
          c.address[$urandom_range(32 - shadow_len[idx], 31)] ^= 1'b1;
      end
    end
    return c;
  endfunction

  // Present one transaction and wait for the accepting edge. The sender idles
  // cycle by cycle with the given chance. Called and returns at a falling edge.
  task automatic issue(input pft_pkg::req_t c, input logic known,
                       input pft_pkg::rsp_t want, input int idle_pct);
    logic        idle;
    logic [63:0] junk;
    pending_t    p;
    forever begin
      idle = (idle_pct > 0) && ($urandom_range(0, 99) < idle_pct);
      if (idle) begin
        junk  = {$urandom, $urandom};
        start <= 1'b0;
        req   <= junk[$bits(pft_pkg::req_t)-1:0];
      end else begin
        start <= 1'b1;
        req   <= c;
      end
      // busy only moves on the rising edge, so its value here holds to the next one
      if (!idle && !busy) break;
      @(negedge clk);
    end
    @(posedge clk);
    p.cmd  = c;
    p.want = table_answer(c);
    if (known) p.want = want;
    predicted_answers.push_back(p);
    @(negedge clk);
  endtask

  // Result checker; the receiver has no way to stall, so every done is taken.
  always @(posedge clk) begin
    pending_t p;
    if (!rst && done) begin
      if (predicted_answers.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: hit %0b status %0d",
                                      rsp.hit, rsp.status);
        mismatches++;
      end else begin
        p = predicted_answers.pop_front();
        if (rsp.hit !== p.want.hit || rsp.status !== p.want.status) begin
          if (mismatches < 10)
            $display({"mismatch op %0b addr %h len %0d v4 %0b: ",
                      "exp hit %0b st %0d, got hit %0b st %0d"},
                     p.cmd.op, p.cmd.address, p.cmd.prefix_len, p.cmd.is_ipv4,
                     p.want.hit, p.want.status, rsp.hit, rsp.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int            pct [3];
    pft_pkg::rsp_t none;
    none        = '0;
    cycles      = 0;
    mismatches  = 0;
    shadow_fill = 0;
    start       = 1'b0;
    req         = '0;
    rst         = 1'b1;
    pct = '{0, 54, 35};

    // Directed: empty table, rejected lengths, extremes, duplicates and the
    // ignored fields of each operation.
    dir_tab = '{
      row(pft_pkg::OP_LOOKUP, 32'h0000_0000, 6'd0,  1'b1, 1'b1, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_INSERT, 32'h1234_5678, 6'd0,  1'b1, 1'b1, 1'b0,
          pft_pkg::STATUS_BAD_LEN),
      row(pft_pkg::OP_INSERT, 32'h1234_5678, 6'd1,  1'b0, 1'b1, 1'b0,
          pft_pkg::STATUS_BAD_LEN),
      row(pft_pkg::OP_INSERT, 32'h1234_5678, 6'd33, 1'b1, 1'b1, 1'b0,
          pft_pkg::STATUS_BAD_LEN),
      row(pft_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, 1'b0,
          pft_pkg::STATUS_BAD_LEN),
      row(pft_pkg::OP_LOOKUP, 32'h1234_5678, 6'd32, 1'b1, 1'b1, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b1, 1'b1, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b1, 1'b1, 1'b1, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  1'b0, 1'b1, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 6'd32, 1'b1, 1'b0, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_INSERT, 32'h0A0B_0C0D, 6'd8,  1'b0, 1'b0, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_LOOKUP, 32'h0AFF_FFFF, 6'd8,  1'b1, 1'b0, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_LOOKUP, 32'h0B00_0000, 6'd8,  1'b1, 1'b0, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_INSERT, 32'hC0A8_0101, 6'd2,  1'b1, 1'b0, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 6'd0,  1'b1, 1'b0, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_LOOKUP, 32'h8000_0000, 6'd0,  1'b1, 1'b0, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_INSERT, 32'h0000_0000, 6'd32, 1'b0, 1'b0, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_INSERT, 32'h0000_0000, 6'd32, 1'b1, 1'b0, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_LOOKUP, 32'h0000_0000, 6'd63, 1'b1, 1'b0, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_LOOKUP, 32'h0000_0000, 6'd32, 1'b0, 1'b1, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_INSERT, 32'h0101_0101, 6'd31, 1'b0, 1'b0, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_LOOKUP, 32'h0101_0100, 6'd0,  1'b1, 1'b0, 1'b0, pft_pkg::STATUS_OK),
      row(pft_pkg::OP_LOOKUP, 32'h0101_0102, 6'd63, 1'b1, 1'b0, 1'b0, pft_pkg::STATUS_OK)
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) issue(dir_tab[i].cmd, dir_tab[i].known, dir_tab[i].want, 0);

    // Random passes: no sender idling, then heavy idling, then moderate.
    // The receiver cannot stall, so only the sender side idles.
    foreach (pct[ph]) begin
      for (int n = 0; n < RAND_PER_PASS; n++) issue(make_txn(), 1'b0, none, pct[ph]);
    end
    start <= 1'b0;

    while (predicted_answers.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);
    if (predicted_answers.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
